// ===== rtl/min_cost_two_path_flow_defines.svh =====
// Assertion macros shared by the checker of the two-path min-cost flow block.
// Needs clk and arst_n in the scope of each use.
`ifndef MIN_COST_TWO_PATH_FLOW_DEFINES_SVH
`define MIN_COST_TWO_PATH_FLOW_DEFINES_SVH

// Same-cycle implication, disabled while reset is asserted.
`define MCTPF_ASSERT_IMP(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) else $error(msg);

// Next-cycle implication, disabled while reset is asserted.
`define MCTPF_ASSERT_NXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) else $error(msg);

`endif

// ===== rtl/mctpf_pkg.sv =====
// Package for the two-path min-cost flow block: widths, codes, defaults, state type.
// No dependencies; used by the top level and its checker.
`timescale 1ns / 1ps

package mctpf_pkg;

	localparam int DEF_MAX_NODES   = 1024;
	localparam int DEF_MAX_EDGES   = 4096;
	localparam int DEF_WEIGHT_BITS = 16;

	localparam int NODE_W      = 11;
	localparam int WEIGHT_IN_W = 16;
	localparam int CMD_W       = 2;
	localparam int COST_W      = 28;
	localparam int PATHS_W     = 2;
	localparam int CFG_IDX_W   = 2;
	localparam int DIST_W      = 30;
	localparam int STEP_W      = NODE_W + 1;

	localparam logic [DIST_W-1:0] DIST_INF = 30'd1000000007;
	localparam logic [COST_W-1:0] COST_MAX = '1;

	localparam logic [CMD_W-1:0] CMD_CLEAR = 2'd0;
	localparam logic [CMD_W-1:0] CMD_LOAD  = 2'd1;
	localparam logic [CMD_W-1:0] CMD_RUN   = 2'd2;

	localparam logic [CFG_IDX_W-1:0] REG_NODE_COUNT  = 2'd0;
	localparam logic [CFG_IDX_W-1:0] REG_SOURCE_NODE = 2'd1;
	localparam logic [CFG_IDX_W-1:0] REG_TARGET_NODE = 2'd2;

	localparam logic [NODE_W-1:0] RST_NODE_COUNT  = 11'd2;
	localparam logic [NODE_W-1:0] RST_SOURCE_NODE = 11'd1;
	localparam logic [NODE_W-1:0] RST_TARGET_NODE = 11'd2;

	// Role of an arc within its edge: two forward arcs and their residual partners.
	localparam logic [1:0] ARC_FWD_A = 2'd0;
	localparam logic [1:0] ARC_REV_A = 2'd1;
	localparam logic [1:0] ARC_FWD_B = 2'd2;
	localparam logic [1:0] ARC_REV_B = 2'd3;

	typedef enum logic [3:0] {
		S_IDLE,
		S_FCLR,
		S_DCLR,
		S_EDGE_RD,
		S_ARC_RD,
		S_ARC_EVAL,
		S_PASS_END,
		S_TGT_RD,
		S_TGT_EVAL,
		S_PRED_RD,
		S_PRED_WAIT,
		S_TEDGE,
		S_DONE
	} state_t;

endpackage

// ===== rtl/min_cost_two_path_flow.sv =====
// Load and clear beats are taken in the idle state and may follow back to back.
// A run beat performs k searches (at most two); each makes Bellman-Ford passes over the
// edge memory (four arc slots per edge, with a distance memory read for each usable arc)
// until a pass changes nothing, then traces the path from the target back to the source.
// Reset clears the edge count and the result valid flag and sets the
// registers to their defaults; the memories are not cleared.
`timescale 1ns / 1ps

module min_cost_two_path_flow import mctpf_pkg::*; #(
	parameter int MAX_NODES   = DEF_MAX_NODES,
	parameter int MAX_EDGES   = DEF_MAX_EDGES,
	parameter int WEIGHT_BITS = DEF_WEIGHT_BITS
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 cfg_we,
	input  logic [CFG_IDX_W-1:0] cfg_index,
	input  logic [NODE_W-1:0]    cfg_data,
	input  logic                 in_valid,
	output logic                 in_stall,
	input  logic [CMD_W-1:0]     cmd,
	input  logic [NODE_W-1:0]    edge_from,
	input  logic [NODE_W-1:0]    edge_to,
	input  logic [WEIGHT_IN_W-1:0] edge_weight,
	output logic                 out_valid,
	input  logic                 out_stall,
	output logic [COST_W-1:0]    total_cost,
	output logic [PATHS_W-1:0]   paths_found
);

	localparam int WB    = (WEIGHT_BITS < WEIGHT_IN_W) ? WEIGHT_BITS : WEIGHT_IN_W;
	localparam int EW    = (MAX_EDGES > 1) ? $clog2(MAX_EDGES) : 1;
	localparam int CW    = $clog2(MAX_EDGES + 1);
	localparam int DN    = MAX_NODES + 1;
	localparam int AW    = $clog2(DN);
	localparam int AID_W = EW + 2;
	localparam int SW    = DIST_W + 2;
	localparam logic [NODE_W-1:0] N_CAP = (MAX_NODES >= 2047) ? '1 : NODE_W'(MAX_NODES);

	typedef struct packed {
		logic [NODE_W-1:0] from;
		logic [NODE_W-1:0] to;
		logic [WB-1:0]     weight;
	} edge_rec_t;

	// Memories.
	edge_rec_t         edge_mem [MAX_EDGES];
	logic [1:0]        flow_mem [MAX_EDGES];
	logic [DIST_W-1:0] dist_mem [DN];
	logic [AID_W-1:0]  pred_mem [DN];

	state_t state_q, state_d;

	logic [NODE_W-1:0] node_count_q, source_q, target_q;
	logic [CW-1:0]     ecnt_q;
	logic              out_valid_q;
	logic [COST_W-1:0] total_q;
	logic [PATHS_W-1:0] paths_out_q;

	logic [NODE_W-1:0] n_q, node_q;
	logic [CW-1:0]     e_q;
	logic [1:0]        arc_j_q;
	logic              changed_q;
	logic [PATHS_W-1:0] paths_q;
	logic [COST_W-1:0] cost_q;
	logic [STEP_W-1:0] steps_q;

	edge_rec_t         edge_rd_q;
	logic [1:0]        flow_rd_q;
	logic [DIST_W-1:0] dist_a_q, dist_b_q;
	logic [AID_W-1:0]  pred_rd_q;

	logic              in_acc;
	logic [NODE_W-1:0] n_c;
	logic              ends_ok;

	logic              arc_rev, arc_pair, arc_from_u, arc_cap, arc_use, arc_last, arc_step;
	logic [NODE_W-1:0] arc_from, arc_to;
	logic signed [SW-1:0] relax_sum;
	logic              relax;
	logic [DIST_W:0]   cost_sum;
	logic [1:0]        flow_new;

	logic              edge_we, edge_re, flow_we, dist_we, pred_we, pred_re;
	logic [EW-1:0]     edge_raddr, flow_waddr;
	logic [1:0]        flow_wdata;
	logic [AW-1:0]     dist_waddr, dist_raddr_a, dist_raddr_b, pred_addr;
	logic              dist_re;
	logic [DIST_W-1:0] dist_wdata;
	logic [STEP_W-1:0] step_lim;

	assign in_stall    = (state_q != S_IDLE);
	assign in_acc      = in_valid && !in_stall;
	assign out_valid   = out_valid_q;
	assign total_cost  = total_q;
	assign paths_found = paths_out_q;

	always_comb begin
		if (node_count_q < 11'd2) begin
			n_c = 11'd2;
		end else if (node_count_q > N_CAP) begin
			n_c = N_CAP;
		end else begin
			n_c = node_count_q;
		end
	end

	assign ends_ok = (source_q != '0) && (source_q <= n_c) &&
		(target_q != '0) && (target_q <= n_c);

	// Decode the current arc from the edge record and its two flow bits.
	assign arc_rev    = (arc_j_q == ARC_REV_A) || (arc_j_q == ARC_REV_B);
	assign arc_pair   = (arc_j_q == ARC_FWD_B) || (arc_j_q == ARC_REV_B);
	assign arc_from_u = (arc_j_q == ARC_FWD_A) || (arc_j_q == ARC_REV_B);
	assign arc_from   = arc_from_u ? edge_rd_q.from : edge_rd_q.to;
	assign arc_to     = arc_from_u ? edge_rd_q.to : edge_rd_q.from;
	assign arc_cap    = arc_rev ? flow_rd_q[arc_pair] : !flow_rd_q[arc_pair];
	assign arc_use    = arc_cap && (edge_rd_q.from != '0) && (edge_rd_q.from <= n_q) &&
		(edge_rd_q.to != '0) && (edge_rd_q.to <= n_q);
	assign arc_last   = (arc_j_q == ARC_REV_B);
	assign arc_step   = (state_q == S_ARC_RD && !arc_use) || (state_q == S_ARC_EVAL);

	assign relax_sum = $signed({2'b00, dist_a_q}) +
		(arc_rev ? -$signed(SW'(edge_rd_q.weight)) : $signed(SW'(edge_rd_q.weight)));
	assign relax     = (dist_a_q != DIST_INF) && (relax_sum < $signed({2'b00, dist_b_q}));

	assign cost_sum = (DIST_W + 1)'(cost_q) + (DIST_W + 1)'(dist_a_q);
	assign flow_new = arc_pair ? {!arc_rev, flow_rd_q[0]} : {flow_rd_q[1], !arc_rev};
	assign step_lim = STEP_W'(n_q) + STEP_W'(1);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		state_d      = state_q;
		edge_we      = 1'b0;
		edge_re      = 1'b0;
		edge_raddr   = e_q[EW-1:0];
		flow_we      = 1'b0;
		flow_waddr   = e_q[EW-1:0];
		flow_wdata   = 2'b00;
		dist_we      = 1'b0;
		dist_waddr   = AW'(node_q);
		dist_wdata   = (node_q == source_q) ? '0 : DIST_INF;
		dist_re      = 1'b0;
		dist_raddr_a = AW'(arc_from);
		dist_raddr_b = AW'(arc_to);
		pred_we      = 1'b0;
		pred_re      = 1'b0;
		pred_addr    = AW'(arc_to);
		case (state_q)
			S_IDLE: begin
				if (in_acc) begin
					if (cmd == CMD_LOAD) begin
						edge_we = (ecnt_q < CW'(MAX_EDGES));
					end else if (cmd == CMD_RUN) begin
						state_d = ends_ok ? S_FCLR : S_DONE;
					end
				end
			end
			S_FCLR: begin
				if (e_q == ecnt_q) begin
					state_d = S_DCLR;
				end else begin
					flow_we = 1'b1;
				end
			end
			S_DCLR: begin
				dist_we = 1'b1;
				if (node_q == n_q) begin
					state_d = S_EDGE_RD;
				end
			end
			S_EDGE_RD: begin
				if (e_q == ecnt_q) begin
					state_d = S_PASS_END;
				end else begin
					edge_re = 1'b1;
					state_d = S_ARC_RD;
				end
			end
			S_ARC_RD: begin
				if (arc_use) begin
					dist_re = 1'b1;
					state_d = S_ARC_EVAL;
				end else begin
					state_d = arc_last ? S_EDGE_RD : S_ARC_RD;
				end
			end
			S_ARC_EVAL: begin
				dist_we    = relax;
				dist_waddr = AW'(arc_to);
				dist_wdata = DIST_W'(relax_sum);
				pred_we    = relax;
				state_d    = arc_last ? S_EDGE_RD : S_ARC_RD;
			end
			S_PASS_END: begin
				state_d = changed_q ? S_EDGE_RD : S_TGT_RD;
			end
			S_TGT_RD: begin
				dist_re      = 1'b1;
				dist_raddr_a = AW'(target_q);
				dist_raddr_b = AW'(target_q);
				state_d      = S_TGT_EVAL;
			end
			S_TGT_EVAL: begin
				state_d = (dist_a_q == DIST_INF) ? S_DONE : S_PRED_RD;
			end
			S_PRED_RD: begin
				// The path is complete once the walk is back at the source or its step count passes the limit.
				if (node_q == source_q || steps_q > step_lim) begin
					state_d = (paths_q == 2'd1) ? S_DONE : S_DCLR;
				end else begin
					pred_re   = 1'b1;
					pred_addr = AW'(node_q);
					state_d   = S_PRED_WAIT;
				end
			end
			S_PRED_WAIT: begin
				edge_re    = 1'b1;
				edge_raddr = pred_rd_q[AID_W-1:2];
				state_d    = S_TEDGE;
			end
			S_TEDGE: begin
				flow_we    = 1'b1;
				flow_waddr = pred_rd_q[AID_W-1:2];
				flow_wdata = flow_new;
				state_d    = S_PRED_RD;
			end
			S_DONE: begin
				if (!out_valid_q) begin
					state_d = S_IDLE;
				end
			end
			default: begin
				state_d = S_IDLE;
			end
		endcase
	end

	// Control registers.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			node_count_q <= RST_NODE_COUNT;
			source_q     <= RST_SOURCE_NODE;
			target_q     <= RST_TARGET_NODE;
			ecnt_q       <= '0;
			out_valid_q  <= 1'b0;
		end else begin
			if (cfg_we) begin
				case (cfg_index)
					REG_NODE_COUNT:  node_count_q <= cfg_data;
					REG_SOURCE_NODE: source_q     <= cfg_data;
					REG_TARGET_NODE: target_q     <= cfg_data;
					default: ;
				endcase
			end
			if (in_acc && cmd == CMD_CLEAR) begin
				ecnt_q <= '0;
			end else if (edge_we) begin
				ecnt_q <= ecnt_q + CW'(1);
			end
			if (state_q == S_DONE && !out_valid_q) begin
				out_valid_q <= 1'b1;
			end else if (out_valid_q && !out_stall) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	// Working registers of a run; each is set before it is used.
	always_ff @(posedge clk) begin
		if (state_q == S_DONE && !out_valid_q) begin
			total_q     <= cost_q;
			paths_out_q <= paths_q;
		end
		case (state_q)
			S_IDLE: begin
				n_q     <= n_c;
				e_q     <= '0;
				paths_q <= '0;
				cost_q  <= '0;
			end
			S_FCLR: begin
				if (e_q == ecnt_q) begin
					node_q <= 11'd1;
				end else begin
					e_q <= e_q + CW'(1);
				end
			end
			S_DCLR: begin
				node_q    <= node_q + 11'd1;
				e_q       <= '0;
				changed_q <= 1'b0;
			end
			S_EDGE_RD: begin
				arc_j_q <= ARC_FWD_A;
			end
			S_ARC_EVAL: begin
				if (relax) begin
					changed_q <= 1'b1;
				end
			end
			S_PASS_END: begin
				e_q       <= '0;
				changed_q <= 1'b0;
			end
			S_TGT_EVAL: begin
				if (dist_a_q != DIST_INF) begin
					cost_q <= (cost_sum > (DIST_W + 1)'(COST_MAX)) ? COST_MAX
						: COST_W'(cost_sum);
				end
				node_q  <= target_q;
				steps_q <= STEP_W'(1);
			end
			S_PRED_RD: begin
				// A second search clears the distances again from node one.
				if (node_q == source_q || steps_q > step_lim) begin
					paths_q <= paths_q + 2'd1;
					node_q  <= 11'd1;
				end
			end
			S_PRED_WAIT: begin
				arc_j_q <= pred_rd_q[1:0];
			end
			S_TEDGE: begin
				node_q  <= arc_from;
				steps_q <= steps_q + STEP_W'(1);
			end
			default: ;
		endcase
		if (arc_step) begin
			arc_j_q <= arc_j_q + 2'd1;
			if (arc_last) begin
				e_q <= e_q + CW'(1);
			end
		end
	end

	always_ff @(posedge clk) begin
		if (edge_we) begin
			edge_mem[ecnt_q[EW-1:0]] <= '{from: edge_from, to: edge_to,
				weight: edge_weight[WB-1:0]};
		end
		if (edge_re) begin
			edge_rd_q <= edge_mem[edge_raddr];
		end
	end

	always_ff @(posedge clk) begin
		if (flow_we) begin
			flow_mem[flow_waddr] <= flow_wdata;
		end
		if (edge_re) begin
			flow_rd_q <= flow_mem[edge_raddr];
		end
	end

	always_ff @(posedge clk) begin
		if (dist_we) begin
			dist_mem[dist_waddr] <= dist_wdata;
		end
		if (dist_re) begin
			dist_a_q <= dist_mem[dist_raddr_a];
			dist_b_q <= dist_mem[dist_raddr_b];
		end
	end

	always_ff @(posedge clk) begin
		if (pred_we) begin
			pred_mem[pred_addr] <= {e_q[EW-1:0], arc_j_q};
		end
		if (pred_re) begin
			pred_rd_q <= pred_mem[pred_addr];
		end
	end

endmodule

// ===== rtl/mctpf_checker.sv =====
// Port-level checker for the two-path min-cost flow block, bound to the top level.
// Depends on mctpf_pkg and the shared assertion macros.
`timescale 1ns / 1ps
`include "min_cost_two_path_flow_defines.svh"

module mctpf_checker import mctpf_pkg::*; (
	input logic                 clk,
	input logic                 arst_n,
	input logic                 in_valid,
	input logic                 in_stall,
	input logic [CMD_W-1:0]     cmd,
	input logic                 out_valid,
	input logic                 out_stall,
	input logic [COST_W-1:0]    total_cost,
	input logic [PATHS_W-1:0]   paths_found
);

	// A result beat held by the receiver keeps its payload.
	`MCTPF_ASSERT_NXT(a_out_hold, out_valid && out_stall, out_valid && $stable(total_cost) && $stable(paths_found), "result beat changed while stalled")

	`MCTPF_ASSERT_IMP(a_paths_range, out_valid, paths_found != 2'd3, "more than two paths reported")

	// With no path found nothing can have been added to the cost.
	`MCTPF_ASSERT_IMP(a_zero_cost, out_valid && paths_found == 2'd0, total_cost == '0, "cost without a path")

	// A run beat always occupies the block for at least the following cycle.
	`MCTPF_ASSERT_NXT(a_run_busy, in_valid && !in_stall && cmd == CMD_RUN, in_stall, "input taken right after a run beat")

endmodule

bind min_cost_two_path_flow mctpf_checker u_mctpf_checker (.*);
